>>> design/pwb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwb_pkg
// Shared types and constants for the polar window bounds pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pwb_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  // Datapath widths: coordinates in 1/16 km with 16 fraction bits.
  localparam int COORD_W = 34;
  localparam int ANGLE_W = 32;

  // Inverse CORDIC gain in Q30.
  localparam logic [29:0] INV_GAIN = 30'd652032874;

  localparam logic [12:0] FULL_TURN = 13'd5760;
  localparam logic [28:0] ANG_90    = 29'd94371840;
  localparam logic [28:0] ANG_180   = 29'd188743680;
  localparam logic [28:0] ANG_360   = 29'd377487360;

  // Arctangent of 2^-i in 2^-20 degree.
  localparam logic [26:0] ATAN_TAB [0:CORDIC_STEPS_MAX-1] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
    27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342,
    27'd58671, 27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833,
    27'd917, 27'd458, 27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
  };

  typedef enum logic [2:0] {
    CASE_QUADRANT = 3'd0,
    CASE_NEG_X    = 3'd1,
    CASE_POS_X    = 3'd2,
    CASE_NEG_Y    = 3'd3,
    CASE_NORTH    = 3'd4,
    CASE_ORIGIN   = 3'd5
  } window_case_t;

endpackage

`default_nettype wire

>>> design/polar_window_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_window_bounds
// Range and azimuth bounds of a square window given by its polar center.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents (lowest bit first)
// s_axis  | in  | center_range 13, center_azimuth 13, side_length 8
// m_axis  | out | max_range 14, min_range 14, max_azimuth 13, min_azimuth 13,
//         |     | window_case 3
// A beat passes 2*CORDIC_STEPS+7 register stages, among them the rotation
// CORDIC and the four-lane vectoring CORDIC stages; every stage has its own
// valid bit. One beat can enter every cycle while s_tready is high.
// A stalled output holds its stage while earlier stages keep filling bubbles.
// Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_window_bounds #(
  parameter int CORDIC_STEPS = pwb_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // center_range, center_azimuth, side_length
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // max_range, min_range, max_azimuth,
                                     // min_azimuth, window_case
);

  localparam int N      = CORDIC_STEPS;
  localparam int W      = pwb_pkg::COORD_W;
  localparam int ZW     = pwb_pkg::ANGLE_W;
  localparam int S_CORN = N + 3;
  localparam int S_VEC0 = N + 4;
  localparam int S_PA   = 2 * N + 4;
  localparam int S_PB   = 2 * N + 5;
  localparam int S_OUT  = 2 * N + 6;
  localparam int NS     = 2 * N + 7;

  typedef struct packed {
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic [6:0]          hk;
  } aux_t;

  logic [NS-1:0] valid;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !valid[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Input stage.
  logic [12:0] in_r;
  logic [12:0] in_az;
  logic [7:0]  in_len;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_r   <= s_tdata[12:0];
      in_az  <= s_tdata[25:13];
      in_len <= s_tdata[33:26];
    end
  end

  // Gain compensation multiply and azimuth reduction.
  logic [42:0] m1_prod;
  logic [12:0] m1_az;
  logic [6:0]  m1_hk;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1_prod <= 43'(in_r) * 43'(pwb_pkg::INV_GAIN);
      m1_az   <= (in_az >= pwb_pkg::FULL_TURN) ? in_az - pwb_pkg::FULL_TURN : in_az;
      m1_hk   <= in_len[7:1];
    end
  end

  // Rotation CORDIC: quadrant fold, then N stages.
  logic signed [W-1:0]  rx [0:N];
  logic signed [W-1:0]  ry [0:N];
  logic signed [ZW-1:0] rz [0:N];
  logic [6:0]           rh [0:N];

  logic [28:0]         fold_mag;
  logic signed [13:0]  fold_zd;
  logic                fold_neg;

  always_comb begin
    fold_mag = 29'((44'(m1_prod) + 44'd8192) >> 14);
    fold_neg = 1'b0;
    if (m1_az <= 13'd1440) begin
      fold_zd = $signed({1'b0, m1_az});
    end else if (m1_az < 13'd4320) begin
      fold_zd  = $signed({1'b0, m1_az}) - 14'sd2880;
      fold_neg = 1'b1;
    end else begin
      fold_zd = $signed({1'b0, m1_az}) - 14'sd5760;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rx[0] <= fold_neg ? -$signed(W'(fold_mag)) : $signed(W'(fold_mag));
      ry[0] <= '0;
      rz[0] <= $signed({{(ZW-30){fold_zd[13]}}, fold_zd, 16'b0});
      rh[0] <= m1_hk;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_rot
    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;
    logic signed [ZW-1:0] at;
    assign dx = ry[g] >>> g;
    assign dy = rx[g] >>> g;
    assign at = $signed(ZW'(pwb_pkg::ATAN_TAB[g]));
    always_ff @(posedge clk) begin
      if (en[3+g]) begin
        if (rz[g] >= 0) begin
          rx[g+1] <= rx[g] - dx;
          ry[g+1] <= ry[g] + dy;
          rz[g+1] <= rz[g] - at;
        end else begin
          rx[g+1] <= rx[g] + dx;
          ry[g+1] <= ry[g] - dy;
          rz[g+1] <= rz[g] + at;
        end
        rh[g+1] <= rh[g];
      end
    end
  end

  // Corner formation: x0 = ry, y0 = rx; lanes UL, UR, LR, LL.
  logic signed [W-1:0] hh;
  logic signed [W-1:0] cxs [0:3];
  logic signed [W-1:0] cys [0:3];

  assign hh = $signed(W'({rh[N], 20'b0}));

  always_comb begin
    cxs[0] = ry[N] - hh;  cys[0] = rx[N] + hh;
    cxs[1] = ry[N] + hh;  cys[1] = rx[N] + hh;
    cxs[2] = ry[N] + hh;  cys[2] = rx[N] - hh;
    cxs[3] = ry[N] - hh;  cys[3] = rx[N] - hh;
  end

  logic signed [W-1:0]  vx [0:3][0:N];
  logic signed [W-1:0]  vy [0:3][0:N];
  logic signed [ZW-1:0] vz [0:3][0:N];
  logic [3:0] vnx  [0:N];
  logic [3:0] vny  [0:N];
  logic [3:0] vzer [0:N];
  aux_t       vaux [0:N];

  for (genvar l = 0; l < 4; l++) begin : g_corner
    always_ff @(posedge clk) begin
      if (en[S_CORN]) begin
        vx[l][0]   <= cys[l][W-1] ? -cys[l] : cys[l];
        vy[l][0]   <= cxs[l][W-1] ? -cxs[l] : cxs[l];
        vz[l][0]   <= '0;
        vnx[0][l]  <= cxs[l][W-1];
        vny[0][l]  <= cys[l][W-1];
        vzer[0][l] <= (cxs[l] == 0) && (cys[l] == 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_CORN]) begin
      vaux[0] <= '{x0: ry[N], y0: rx[N], hk: rh[N]};
    end
  end

  // Vectoring CORDIC, four lanes.
  for (genvar g = 0; g < N; g++) begin : g_vec
    logic signed [ZW-1:0] at;
    assign at = $signed(ZW'(pwb_pkg::ATAN_TAB[g]));
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;
      assign dx = vy[l][g] >>> g;
      assign dy = vx[l][g] >>> g;
      always_ff @(posedge clk) begin
        if (en[S_VEC0+g]) begin
          if (vy[l][g] >= 0) begin
            vx[l][g+1] <= vx[l][g] + dx;
            vy[l][g+1] <= vy[l][g] - dy;
            vz[l][g+1] <= vz[l][g] + at;
          end else begin
            vx[l][g+1] <= vx[l][g] - dx;
            vy[l][g+1] <= vy[l][g] + dy;
            vz[l][g+1] <= vz[l][g] - at;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[S_VEC0+g]) begin
        vnx[g+1]  <= vnx[g];
        vny[g+1]  <= vny[g];
        vzer[g+1] <= vzer[g];
        vaux[g+1] <= vaux[g];
      end
    end
  end

  // Magnitude scaling and angle unfolding.
  logic [62:0] pa_prod [0:3];
  logic [28:0] pa_full [0:3];
  logic [3:0]  pa_nx;
  logic [3:0]  pa_ny;
  aux_t        pa_aux;
  logic [28:0] zc   [0:3];
  logic [32:0] cxc  [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (vz[l][N] < 0) begin
        zc[l] = '0;
      end else if (vz[l][N] > $signed(ZW'(pwb_pkg::ANG_90))) begin
        zc[l] = pwb_pkg::ANG_90;
      end else begin
        zc[l] = vz[l][N][28:0];
      end
      cxc[l] = vx[l][N][W-1] ? '0 : vx[l][N][32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PA]) begin
      for (int l = 0; l < 4; l++) begin
        if (vzer[N][l]) begin
          pa_prod[l] <= '0;
          pa_full[l] <= '0;
        end else begin
          pa_prod[l] <= 63'(cxc[l]) * 63'(pwb_pkg::INV_GAIN);
          if (!vnx[N][l]) begin
            pa_full[l] <= vny[N][l] ? pwb_pkg::ANG_180 - zc[l] : zc[l];
          end else begin
            pa_full[l] <= vny[N][l] ? pwb_pkg::ANG_180 + zc[l] : pwb_pkg::ANG_360 - zc[l];
          end
        end
      end
      pa_nx  <= vnx[N];
      pa_ny  <= vny[N];
      pa_aux <= vaux[N];
    end
  end

  // Output rounding.
  logic [16:0] pb_mag [0:3];
  logic [13:0] pb_ang [0:3];
  logic [3:0]  pb_nx;
  logic [3:0]  pb_ny;
  aux_t        pb_aux;

  always_ff @(posedge clk) begin
    if (en[S_PB]) begin
      for (int l = 0; l < 4; l++) begin
        pb_mag[l] <= 17'((64'(pa_prod[l]) + (64'd1 << 45)) >> 46);
        pb_ang[l] <= 14'((30'(pa_full[l]) + 30'd32768) >> 16);
      end
      pb_nx  <= pa_nx;
      pb_ny  <= pa_ny;
      pb_aux <= pa_aux;
    end
  end

  // Bounds, case and output register.
  logic [16:0] mx_r;
  logic [16:0] mn_r;
  logic [13:0] mx_a;
  logic [13:0] mn_a;
  logic signed [W-1:0] ex0;
  logic signed [W-1:0] ey0;
  logic signed [W-1:0] eh;
  logic signed [W-1:0] edge_v;
  logic signed [W:0]   edge_t;
  logic [13:0] nx_minr;
  logic [13:0] nx_maxa;
  logic [13:0] nx_mina;
  pwb_pkg::window_case_t nx_case;
  logic x_all;
  logic x_none;
  logic y_all;
  logic y_none;

  always_comb begin
    mx_r = pb_mag[0];
    mn_r = pb_mag[0];
    mx_a = pb_ang[0];
    mn_a = pb_ang[0];
    for (int l = 1; l < 4; l++) begin
      if (pb_mag[l] > mx_r) mx_r = pb_mag[l];
      if (pb_mag[l] < mn_r) mn_r = pb_mag[l];
      if (pb_ang[l] > mx_a) mx_a = pb_ang[l];
      if (pb_ang[l] < mn_a) mn_a = pb_ang[l];
    end
    ex0    = pb_aux.x0;
    ey0    = pb_aux.y0;
    eh     = $signed(W'({pb_aux.hk, 20'b0}));
    x_all  = &pb_nx;
    x_none = ~|pb_nx;
    y_all  = &pb_ny;
    y_none = ~|pb_ny;
    nx_maxa = mx_a;
    nx_mina = mn_a;
    edge_v  = '0;
    if ((x_all || x_none) && (y_all || y_none)) begin
      nx_case = pwb_pkg::CASE_QUADRANT;
    end else if (x_all) begin
      nx_case = pwb_pkg::CASE_NEG_X;
      edge_v  = -(ex0 + eh);
    end else if (x_none) begin
      nx_case = pwb_pkg::CASE_POS_X;
      edge_v  = ex0 - eh;
    end else if (y_all) begin
      nx_case = pwb_pkg::CASE_NEG_Y;
      edge_v  = -(ey0 + eh);
    end else if (y_none) begin
      nx_case = pwb_pkg::CASE_NORTH;
      edge_v  = ey0 - eh;
      nx_maxa = pb_ang[2];
      nx_mina = pb_ang[3];
    end else begin
      nx_case = pwb_pkg::CASE_ORIGIN;
      nx_maxa = 14'(pwb_pkg::FULL_TURN);
      nx_mina = '0;
    end
    edge_t = $signed({edge_v[W-1], edge_v}) + $signed((W+1)'(32768));
    case (nx_case)
      pwb_pkg::CASE_QUADRANT: nx_minr = mn_r[13:0];
      pwb_pkg::CASE_ORIGIN:   nx_minr = '0;
      default:                nx_minr = edge_t[29:16];
    endcase
  end

  logic [13:0] o_maxr;
  logic [13:0] o_minr;
  logic [12:0] o_maxa;
  logic [12:0] o_mina;
  logic [2:0]  o_case;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      o_maxr <= mx_r[13:0];
      o_minr <= nx_minr;
      o_maxa <= nx_maxa[12:0];
      o_mina <= nx_mina[12:0];
      o_case <= nx_case;
    end
  end

  assign m_tdata = {7'b0, o_case, o_mina, o_maxa, o_minr, o_maxr};

endmodule

`default_nettype wire

>>> design/pwb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwb_checker
// Port-level checks for the polar window bounds pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[56:54] <= pwb_pkg::CASE_ORIGIN)
    else $error("window case code out of range");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[56:54] == pwb_pkg::CASE_ORIGIN |->
      m_tdata[27:14] == 14'd0 && m_tdata[53:41] == 13'd0 &&
      m_tdata[40:28] == pwb_pkg::FULL_TURN)
    else $error("enclosed-origin bounds wrong");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind polar_window_bounds pwb_checker u_pwb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_polar_window_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_window_bounds
// Self-checking bench for the polar window bounds pipeline. A directed table
// of windows is sent first: extremes, each axis case, the enclosed origin and
// azimuths past a full turn. About 1200 random windows follow. The bench has
// its own fixed-point model of the block for expected bounds; directed rows
// may carry fixed ones instead. Output beats are checked in order, one field
// at a time. The sender works in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polar_window_bounds;

  localparam int     STEPS      = pwb_pkg::CORDIC_STEPS_DEF;
  localparam longint GAIN_Q30   = 652032874;
  localparam longint TURN       = 5760;
  localparam longint A90        = longint'(1440) * 65536;
  localparam longint A180       = longint'(2880) * 65536;
  localparam longint A360       = longint'(5760) * 65536;
  localparam int     N_RANDOM   = 1200;
  localparam int     IDLE_LIMIT = 5000;
  localparam int     TAIL       = 2 * STEPS + 60;
  localparam int     HOLD_LEN   = 400;

  typedef struct packed {
    pwb_pkg::window_case_t wcase;
    logic [12:0]  min_az;
    logic [12:0]  max_az;
    logic [13:0]  min_range;
    logic [13:0]  max_range;
  } bounds_t;

  typedef struct {
    logic [12:0] range;
    logic [12:0] az;
    logic [7:0]  side;
    bit          typed;
    bounds_t     fixed;
  } window_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  bounds_t pending_bounds[$];
  int      errors = 0;
  int      results_seen = 0;
  int      case_hits[6];
  int      idle_cycles = 0;
  bit      long_hold_req = 0;

  polar_window_bounds dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint round16(longint v);
    return (v + (longint'(1) << 15)) >>> 16;
  endfunction

  function automatic void corner_polar(input longint x, input longint y,
                                       output longint mag, output longint ang);
    longint ax, ay, vx, vy, z, dx, dy, full;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    vx = ay;
    vy = ax;
    z = 0;
    if (ax == 0 && ay == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; z += longint'(pwb_pkg::ATAN_TAB[i]);
      end else begin
        vx -= dx; vy += dy; z -= longint'(pwb_pkg::ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > A90) z = A90;
    if (vx < 0) vx = 0;
    mag = (vx * GAIN_Q30 + (longint'(1) << 45)) >>> 46;
    if (x >= 0) full = (y >= 0) ? z : A180 - z;
    else full = (y < 0) ? A180 + z : A360 - z;
    ang = round16(full);
  endfunction

  function automatic bounds_t predict_bounds(logic [12:0] r_in, logic [12:0] az_in,
                                             logic [7:0] side_in);
    longint r, az, h, cx, cy, z, dx, dy, x0, y0;
    longint xs[4], ys[4], mg[4], an[4];
    longint maxr, minr, maxa, mina;
    int negx, negy;
    bounds_t b;
    r = longint'(r_in);
    az = longint'(az_in) % TURN;
    h = (longint'(side_in / 2) * 16) * 65536;
    cy = 0;
    negx = 0;
    negy = 0;
    cx = ((r * 65536) * GAIN_Q30 + (longint'(1) << 29)) >>> 30;
    if (az <= 1440) begin
      z = az;
    end else if (az < 4320) begin
      z = az - 2880;
      cx = -cx;
    end else begin
      z = az - TURN;
    end
    z *= 65536;
    for (int i = 0; i < STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(pwb_pkg::ATAN_TAB[i]);
      end else begin
        cx += dx; cy -= dy; z += longint'(pwb_pkg::ATAN_TAB[i]);
      end
    end
    x0 = cy;
    y0 = cx;
    xs[0] = x0 - h; ys[0] = y0 + h;
    xs[1] = x0 + h; ys[1] = y0 + h;
    xs[2] = x0 + h; ys[2] = y0 - h;
    xs[3] = x0 - h; ys[3] = y0 - h;
    for (int i = 0; i < 4; i++) begin
      if (xs[i] < 0) negx++;
      if (ys[i] < 0) negy++;
      corner_polar(xs[i], ys[i], mg[i], an[i]);
    end
    maxr = mg[0]; minr = mg[0]; maxa = an[0]; mina = an[0];
    for (int i = 1; i < 4; i++) begin
      if (mg[i] > maxr) maxr = mg[i];
      if (mg[i] < minr) minr = mg[i];
      if (an[i] > maxa) maxa = an[i];
      if (an[i] < mina) mina = an[i];
    end
    if ((negx == 0 || negx == 4) && (negy == 0 || negy == 4)) begin
      b.wcase = pwb_pkg::CASE_QUADRANT;
    end else if (negx == 4) begin
      b.wcase = pwb_pkg::CASE_NEG_X;
      minr = round16(-xs[1]);
    end else if (negx == 0) begin
      b.wcase = pwb_pkg::CASE_POS_X;
      minr = round16(xs[0]);
    end else if (negy == 4) begin
      b.wcase = pwb_pkg::CASE_NEG_Y;
      minr = round16(-ys[0]);
    end else if (negy == 0) begin
      b.wcase = pwb_pkg::CASE_NORTH;
      minr = round16(ys[2]);
      maxa = an[2];
      mina = an[3];
    end else begin
      b.wcase = pwb_pkg::CASE_ORIGIN;
      minr = 0;
      mina = 0;
      maxa = TURN;
    end
    b.max_range = maxr[13:0];
    b.min_range = minr[13:0];
    b.max_az = maxa[12:0];
    b.min_az = mina[12:0];
    return b;
  endfunction

  // Sends one window; returns once the beat has been accepted.
  task automatic send_window(logic [12:0] r, logic [12:0] az, logic [7:0] side,
                             bit typed, bounds_t fixed);
    s_tdata <= {6'd0, side, az, r};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_bounds.push_back(typed ? fixed : predict_bounds(r, az, side));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bounds.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall pattern is picked anew at random moments; one long hold on request.
  initial begin
    int mode;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold_req = 0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = int'($urandom_range(0, 2));
        case (mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    bounds_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = bounds_t'(m_tdata[56:0]);
      if (pending_bounds.size() == 0) begin
        $error("output beat with no expected result: %h", m_tdata);
        errors++;
      end else begin
        want = pending_bounds.pop_front();
        results_seen++;
        if (got.wcase <= pwb_pkg::CASE_ORIGIN) case_hits[got.wcase]++;
        if (got.max_range !== want.max_range) begin
          $error("max_range expected %0d got %0d", want.max_range, got.max_range);
          errors++;
        end
        if (got.min_range !== want.min_range) begin
          $error("min_range expected %0d got %0d", want.min_range, got.min_range);
          errors++;
        end
        if (got.max_az !== want.max_az) begin
          $error("max_azimuth expected %0d got %0d", want.max_az, got.max_az);
          errors++;
        end
        if (got.min_az !== want.min_az) begin
          $error("min_azimuth expected %0d got %0d", want.min_az, got.min_az);
          errors++;
        end
        if (got.wcase !== want.wcase) begin
          $error("window_case expected %0d got %0d", want.wcase, got.wcase);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("** polar_window_bounds: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    window_row_t rows[$];
    bounds_t zero_b;
    bounds_t none_b;
    int burst_left, r_sel, az_i;
    logic [12:0] r, az;
    logic [7:0] side;
    zero_b = '{min_az: 13'd0, max_az: 13'd0, min_range: 14'd0, max_range: 14'd0,
               wcase: pwb_pkg::CASE_QUADRANT};
    none_b = zero_b;
    rows.push_back('{13'd0, 13'd0, 8'd0, 1'b1, zero_b});
    rows.push_back('{13'd0, 13'd5759, 8'd1, 1'b1, zero_b});
    rows.push_back('{13'd0, 13'd0, 8'd255, 1'b0, none_b});
    rows.push_back('{13'd8191, 13'd0, 8'd0, 1'b0, none_b});
    rows.push_back('{13'd8191, 13'd5759, 8'd255, 1'b0, none_b});
    rows.push_back('{13'd8191, 13'd8191, 8'd255, 1'b0, none_b});
    rows.push_back('{13'd8191, 13'd5760, 8'd2, 1'b0, none_b});
    rows.push_back('{13'd100, 13'd1440, 8'd4, 1'b0, none_b});
    rows.push_back('{13'd100, 13'd2880, 8'd4, 1'b0, none_b});
    rows.push_back('{13'd100, 13'd4320, 8'd4, 1'b0, none_b});
    rows.push_back('{13'd64, 13'd0, 8'd2, 1'b0, none_b});
    rows.push_back('{13'd64, 13'd1440, 8'd2, 1'b0, none_b});
    rows.push_back('{13'd64, 13'd2880, 8'd2, 1'b0, none_b});
    rows.push_back('{13'd64, 13'd4320, 8'd2, 1'b0, none_b});
    rows.push_back('{13'd32, 13'd0, 8'd4, 1'b0, none_b});
    rows.push_back('{13'd32, 13'd1440, 8'd4, 1'b0, none_b});
    rows.push_back('{13'd16, 13'd0, 8'd4, 1'b0, none_b});
    rows.push_back('{13'd16, 13'd700, 8'd6, 1'b0, none_b});
    rows.push_back('{13'd8191, 13'd5759, 8'd0, 1'b0, none_b});
    rows.push_back('{13'd4000, 13'd5758, 8'd3, 1'b0, none_b});
    rows.push_back('{13'd2000, 13'd3000, 8'd200, 1'b0, none_b});
    rows.push_back('{13'd5555, 13'd7000, 8'd128, 1'b0, none_b});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_window(rows[i].range, rows[i].az, rows[i].side,
                                  rows[i].typed, rows[i].fixed);
    drain_results();

    burst_left = int'($urandom_range(1, 30));
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) long_hold_req = 1;
      if (n == 700) drain_results();
      r_sel = int'($urandom_range(0, 9));
      if (r_sel < 5) r = 13'($urandom_range(0, 2500));
      else if (r_sel < 9) r = 13'($urandom_range(0, 8191));
      else r = 13'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
        0: az_i = int'($urandom_range(5760, 8191));
        1, 2: az_i = 1440 * int'($urandom_range(0, 3)) + int'($urandom_range(0, 8)) - 4;
        default: az_i = int'($urandom_range(0, 5759));
      endcase
      if (az_i < 0) az_i = 0;
      az = 13'(az_i);
      side = 8'($urandom_range(0, 255));
      send_window(r, az, side, 1'b0, none_b);
      burst_left--;
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = int'($urandom_range(1, 30));
      end
    end
    drain_results();
    repeat (TAIL) @(posedge clk);

    $display("checked %0d windows: quadrant %0d, -x %0d, +x %0d, -y %0d, north %0d,",
             results_seen, case_hits[0], case_hits[1], case_hits[2], case_hits[3],
             case_hits[4]);
    $display("origin enclosed %0d; mismatches %0d", case_hits[5], errors);
    if (errors == 0 && pending_bounds.size() == 0) begin
      $display("** polar_window_bounds: PASSED **");
    end else begin
      $display("** polar_window_bounds: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
design/pwb_pkg.sv
design/polar_window_bounds.sv
design/pwb_checker.sv
sim/tb_polar_window_bounds.sv
